>>> hw/rtl/aes_cpc_pkg.sv
// ----------------------------------------------------------------------------
// aes_cpc_pkg
// Shared types, register indexes, s-box table and round functions for the
// counter-mode packet cipher.
// ----------------------------------------------------------------------------
package aes_cpc_pkg;

   localparam int FifoDepth = 4;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_of_packet;
      logic        last_of_packet;
      logic [63:0] pkt_id;
      logic [31:0] src_node;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
   } rsp_type;

   // one byte handed from the front to the engine
   typedef struct packed {
      logic [7:0]   data_byte;
      logic         last;
      logic         new_block;
      logic [3:0]   pos;
      logic [127:0] ctr;
   } work_type;

   typedef struct packed {
      logic         key_size;
      logic [255:0] key;
   } key_cfg_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_RUN,
      ENG_EMIT
   } engine_state_type;

   localparam logic [2:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] rcon_byte(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0:    r = 8'h01;
         4'd1:    r = 8'h02;
         4'd2:    r = 8'h04;
         4'd3:    r = 8'h08;
         4'd4:    r = 8'h10;
         4'd5:    r = 8'h20;
         4'd6:    r = 8'h40;
         4'd7:    r = 8'h80;
         4'd8:    r = 8'h1b;
         4'd9:    r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // one full round: subbytes, shiftrows, mixcolumns (skipped on the final), add key
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic final_rnd);
      logic [7:0]   sb [16];
      logic [7:0]   t  [16];
      logic [7:0]   m  [16];
      logic [7:0]   all;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         sb[i] = SBOX[s[127-8*i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c+r] = sb[4*((c+r)%4)+r];
         end
      end
      for (int c = 0; c < 4; c++) begin
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
         m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
         m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
         m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
      end
      for (int i = 0; i < 16; i++) begin
         res[127-8*i -: 8] = (final_rnd ? t[i] : m[i]) ^ rk[127-8*i -: 8];
      end
      return res;
   endfunction

endpackage

>>> hw/rtl/aes_cpc_front.sv
// ----------------------------------------------------------------------------
// aes_cpc_front
// Tracks packet ids, byte position and block counter; builds the counter
// block for each byte that opens a keystream block.
// ----------------------------------------------------------------------------
module aes_cpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  aes_cpc_pkg::req_type req,
   output aes_cpc_pkg::work_type work
);

   logic [63:0] pid_ff, pid_in;
   logic [31:0] sender_ff, sender_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [3:0]  pos_ff, pos_in;

   logic [63:0] pid_eff;
   logic [31:0] sender_eff;
   logic [31:0] cnt_eff;
   logic [3:0]  pos_eff;

   always_comb begin
      if (req.first_of_packet) begin
         pid_eff    = req.pkt_id;
         sender_eff = req.src_node;
         cnt_eff    = '0;
         pos_eff    = '0;
      end else begin
         pid_eff    = pid_ff;
         sender_eff = sender_ff;
         cnt_eff    = cnt_ff;
         pos_eff    = pos_ff;
      end

      work.data_byte = req.data_byte;
      work.last      = req.last_of_packet;
      work.new_block = (pos_eff == 4'd0);
      work.pos       = pos_eff;
      // ids little-endian, counter big-endian
      for (int i = 0; i < 8; i++) begin
         work.ctr[127-8*i -: 8] = pid_eff[8*i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         work.ctr[63-8*i -: 8] = sender_eff[8*i +: 8];
      end
      work.ctr[31:0] = cnt_eff;

      pid_in    = pid_eff;
      sender_in = sender_eff;
      pos_in    = pos_eff + 4'd1;
      cnt_in    = (pos_eff == 4'hf) ? cnt_eff + 32'd1 : cnt_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff    <= '0;
         sender_ff <= '0;
         cnt_ff    <= '0;
         pos_ff    <= '0;
      end else if (take) begin
         pid_ff    <= pid_in;
         sender_ff <= sender_in;
         cnt_ff    <= cnt_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

>>> hw/rtl/aes_cpc_fifo.sv
// ----------------------------------------------------------------------------
// aes_cpc_fifo
// Short queue of work beats between the front and the cipher engine.
// ----------------------------------------------------------------------------
module aes_cpc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  aes_cpc_pkg::work_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output aes_cpc_pkg::work_type head
);

   localparam int PtrW = $clog2(aes_cpc_pkg::FifoDepth);

   aes_cpc_pkg::work_type store_ff [aes_cpc_pkg::FifoDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;

   always_comb begin
      full  = (count_ff == (PtrW+1)'(aes_cpc_pkg::FifoDepth));
      valid = (count_ff != '0);
      head  = store_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/aes_cpc_engine.sv
// ----------------------------------------------------------------------------
// aes_cpc_engine
// Runs one cipher round per cycle with the key schedule expanded alongside,
// then xors each queued byte with its keystream byte into the result register.
// ----------------------------------------------------------------------------
module aes_cpc_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  aes_cpc_pkg::key_cfg_type key_cfg,
   input  logic                     wk_valid,
   input  aes_cpc_pkg::work_type    wk_head,
   output logic                     wk_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output aes_cpc_pkg::rsp_type     rsp_data
);

   aes_cpc_pkg::engine_state_type state_ff, state_in;

   logic [127:0] st_ff, st_in;
   logic [127:0] rk_ff, rk_in;
   logic [127:0] prev_ff, prev_in;
   logic [127:0] ks_ff, ks_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic         out_valid_ff, out_valid_in;
   aes_cpc_pkg::rsp_type out_ff, out_in;

   logic [127:0] base;
   logic [127:0] key_next;
   logic [31:0]  w3, rot, t;
   logic [31:0]  n0, n1, n2, n3;
   logic [3:0]   nr;
   logic         last_rnd;
   logic         out_space;
   logic         out_load;

   always_comb begin
      // key schedule step for round rnd_ff + 1
      w3  = rk_ff[31:0];
      rot = {w3[23:0], w3[31:24]};
      if (!key_cfg.key_size) begin
         base = rk_ff;
         t    = aes_cpc_pkg::sub_word(rot) ^ {aes_cpc_pkg::rcon_byte(rnd_ff), 24'd0};
      end else begin
         base = prev_ff;
         if (rnd_ff[0]) begin
            t = aes_cpc_pkg::sub_word(rot) ^
                {aes_cpc_pkg::rcon_byte({1'b0, rnd_ff[3:1]}), 24'd0};
         end else begin
            t = aes_cpc_pkg::sub_word(w3);
         end
      end
      n0 = base[127:96] ^ t;
      n1 = base[95:64]  ^ n0;
      n2 = base[63:32]  ^ n1;
      n3 = base[31:0]   ^ n2;
      if (key_cfg.key_size && (rnd_ff == 4'd0)) begin
         key_next = key_cfg.key[127:0];
      end else begin
         key_next = {n0, n1, n2, n3};
      end
      nr       = key_cfg.key_size ? 4'd14 : 4'd10;
      last_rnd = ((rnd_ff + 4'd1) == nr);

      out_space = !out_valid_ff || rsp_pop;

      state_in = state_ff;
      st_in    = st_ff;
      rk_in    = rk_ff;
      prev_in  = prev_ff;
      ks_in    = ks_ff;
      rnd_in   = rnd_ff;
      wk_pop   = 1'b0;
      out_load = 1'b0;

      case (state_ff)
         aes_cpc_pkg::ENG_IDLE: begin
            if (wk_valid && wk_head.new_block) begin
               st_in    = wk_head.ctr ^ key_cfg.key[255:128];
               rk_in    = key_cfg.key[255:128];
               rnd_in   = 4'd0;
               state_in = aes_cpc_pkg::ENG_RUN;
            end else if (wk_valid && out_space) begin
               wk_pop   = 1'b1;
               out_load = 1'b1;
            end
         end
         aes_cpc_pkg::ENG_RUN: begin
            st_in   = aes_cpc_pkg::aes_round(st_ff, key_next, last_rnd);
            prev_in = rk_ff;
            rk_in   = key_next;
            rnd_in  = rnd_ff + 4'd1;
            if (last_rnd) begin
               ks_in    = st_in;
               state_in = aes_cpc_pkg::ENG_EMIT;
            end
         end
         aes_cpc_pkg::ENG_EMIT: begin
            if (out_space) begin
               wk_pop   = 1'b1;
               out_load = 1'b1;
               state_in = aes_cpc_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = aes_cpc_pkg::ENG_IDLE;
         end
      endcase

      out_in.out_byte = wk_head.data_byte ^ ks_in[{~wk_head.pos, 3'b000} +: 8];
      out_in.last_out = wk_head.last;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aes_cpc_pkg::ENG_IDLE;
         out_valid_ff <= 1'b0;
         rnd_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         rnd_ff       <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff   <= st_in;
      rk_ff   <= rk_in;
      prev_ff <= prev_in;
      ks_ff   <= ks_in;
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == aes_cpc_pkg::ENG_RUN |-> rnd_ff < 4'd14)
      else $error("round counter ran past the last round");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      wk_pop |-> wk_valid)
      else $error("work queue popped while empty");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_pop))
      else $error("result register overwritten before it was taken");

endmodule

>>> hw/rtl/aes_ctr_packet_cipher_core.sv
// a byte within a keystream block is held in the work queue, then in the result register
// a byte that opens a block first waits for the round loop: one round a cycle
// throughput: one byte per cycle within a block, set by the result register and work queue,
// while the result register is popped as it fills; a block start first costs the round loop
// reset (synchronous, high) clears key, ids, counter, byte position and all queues
// ----------------------------------------------------------------------------
// aes_ctr_packet_cipher_core
// Counter-mode packet cipher: register file, front, work queue and engine.
// ----------------------------------------------------------------------------
module aes_ctr_packet_cipher_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  aes_cpc_pkg::req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output aes_cpc_pkg::rsp_type rsp_data,
   input  logic                 csr_write_en,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_wdata
);

   logic        key_size_ff;
   logic [63:0] key_word_ff [4];

   aes_cpc_pkg::key_cfg_type key_cfg;
   aes_cpc_pkg::work_type    work;
   aes_cpc_pkg::work_type    wk_head;
   logic                     take;
   logic                     wk_valid;
   logic                     wk_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            key_word_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            aes_cpc_pkg::CSR_KEY_SIZE:   key_size_ff    <= csr_wdata[0];
            aes_cpc_pkg::CSR_KEY_WORD_0: key_word_ff[0] <= csr_wdata;
            aes_cpc_pkg::CSR_KEY_WORD_1: key_word_ff[1] <= csr_wdata;
            aes_cpc_pkg::CSR_KEY_WORD_2: key_word_ff[2] <= csr_wdata;
            aes_cpc_pkg::CSR_KEY_WORD_3: key_word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      key_cfg.key_size = key_size_ff;
      key_cfg.key      = {key_word_ff[0], key_word_ff[1], key_word_ff[2], key_word_ff[3]};
      take             = req_push && !req_full;
   end

   aes_cpc_front u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .work  (work)
   );

   aes_cpc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (work),
      .full      (req_full),
      .pop       (wk_pop),
      .valid     (wk_valid),
      .head      (wk_head)
   );

   aes_cpc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .key_cfg   (key_cfg),
      .wk_valid  (wk_valid),
      .wk_head   (wk_head),
      .wk_pop    (wk_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
